// ===== src/block_transfer_arq_sender_defines.svh =====
// Assertion macros for the top-level RTL file, its only includer.
// The clock is clk and the active-low reset is rst_n in that module.
`ifndef BLOCK_TRANSFER_ARQ_SENDER_DEFINES_SVH
`define BLOCK_TRANSFER_ARQ_SENDER_DEFINES_SVH

`ifndef SYNTH
`define BTAS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btas assertion failed");
`define BTAS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btas assertion failed");
`else
`define BTAS_ASSERT_IMP(label, ante, cons)
`define BTAS_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== src/btas_pkg.sv =====
package btas_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [12:0] MAX_BLOCK       = 13'd4096;
  localparam logic [12:0] RST_BLK_LIMIT   = 13'd4096;
  localparam logic [3:0]  RST_RETRY_LIMIT = 4'd3;
  localparam logic [19:0] RST_TIMEOUT     = 20'd5000;

  localparam logic [CFG_IDX_W-1:0] CFG_BLK_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_SEND = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    KD_START = 3'd0,
    KD_READY = 3'd1,
    KD_ACK   = 3'd2,
    KD_NAK   = 3'd3,
    KD_DEV   = 3'd4,
    KD_OTHER = 3'd5,
    KD_STOP  = 3'd6,
    KD_TICK  = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    FR_NONE      = 3'd0,
    FR_READY_HDR = 3'd1,
    FR_START_HDR = 3'd2,
    FR_DATA      = 3'd3,
    FR_END       = 3'd4
  } frame_t;

  typedef enum logic [2:0] {
    NT_NONE     = 3'd0,
    NT_STARTED  = 3'd1,
    NT_PROGRESS = 3'd2,
    NT_DONE     = 3'd3,
    NT_ERROR    = 3'd4
  } notice_t;

  typedef enum logic [2:0] {
    ER_NONE     = 3'd0,
    ER_BUSY     = 3'd1,
    ER_NO_LINK  = 3'd2,
    ER_TIMEOUTS = 3'd3,
    ER_NAKS     = 3'd4,
    ER_DEVICE   = 3'd5
  } err_t;

  typedef struct packed {
    logic        last;
    logic [31:0] sent_total;
    err_t        error_code;
    notice_t     notice;
    logic [31:0] header_size;
    logic [12:0] block_length;
    logic [31:0] block_offset;
    frame_t      frame_kind;
  } res_t;

  // One queue entry holds all results of one input word.
  typedef struct packed {
    logic two;
    res_t res1;
    res_t res0;
  } entry_t;

  typedef struct packed {
    phase_t phase;
    logic   timer_running;
  } front_status_t;

  typedef struct packed {
    logic pend_valid;
    logic out_valid;
  } back_status_t;

endpackage

// ===== src/btas_front.sv =====
module btas_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [btas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [btas_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_fire,
  input  btas_pkg::kind_t                    in_kind,
  input  logic [31:0]                        in_file_size,
  input  logic                               in_link_up,
  output logic                               push,
  output btas_pkg::entry_t                   push_entry,
  output btas_pkg::front_status_t            status
);
  import btas_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] acked_r, acked_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [12:0] block_bytes_r, block_bytes_nxt;
  logic [3:0]  retries_r, retries_nxt;
  logic [19:0] timer_left_r, timer_left_nxt;
  logic        timer_run_r, timer_run_nxt;

  logic [12:0] blk_limit_r;
  logic [3:0]  retry_limit_r;
  logic [19:0] timeout_r;

  logic [12:0] bs_eff;
  logic        ack_adv;
  logic [31:0] blk_add;
  logic [31:0] acked_src;
  logic [31:0] rem_src;
  logic        snd_end;
  logic [12:0] snd_len;
  logic [3:0]  retry_inc;
  res_t        snd_res;
  res_t        r0, r1;
  logic        two;
  logic        do_send;

  always_comb begin
    if (blk_limit_r == 13'd0) begin
      bs_eff = 13'd1;
    end else if (blk_limit_r > MAX_BLOCK) begin
      bs_eff = MAX_BLOCK;
    end else begin
      bs_eff = blk_limit_r;
    end
  end

  // The remaining byte count is kept alongside the acked offset, so the next
  // block length needs only one subtract and one compare.
  assign ack_adv   = (in_kind == KD_ACK) && (phase_r == PH_SEND);
  assign blk_add   = ack_adv ? {19'd0, block_bytes_r} : 32'd0;
  assign acked_src = acked_r + blk_add;
  assign rem_src   = rem_r - blk_add;
  assign snd_end   = (rem_src == 32'd0);
  assign snd_len   = (rem_src < {19'd0, bs_eff}) ? rem_src[12:0] : bs_eff;
  assign retry_inc = retries_r + 4'd1;

  always_comb begin
    snd_res = '0;
    if (snd_end) begin
      snd_res.frame_kind = FR_END;
      snd_res.notice     = NT_DONE;
    end else begin
      snd_res.frame_kind   = FR_DATA;
      snd_res.block_offset = acked_src;
      snd_res.block_length = snd_len;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    total_nxt       = total_r;
    acked_nxt       = acked_r;
    rem_nxt         = rem_r;
    block_bytes_nxt = block_bytes_r;
    retries_nxt     = retries_r;
    timer_left_nxt  = timer_left_r;
    timer_run_nxt   = timer_run_r;
    r0      = '0;
    r1      = '0;
    two     = 1'b0;
    push    = 1'b0;
    do_send = 1'b0;

    if (in_fire) begin
      // Any received frame stops the timer.
      if (in_kind != KD_START && in_kind != KD_STOP && in_kind != KD_TICK) begin
        timer_run_nxt  = 1'b0;
        timer_left_nxt = 20'd0;
      end

      unique case (in_kind)
        KD_START: begin
          push = 1'b1;
          if (phase_r != PH_IDLE) begin
            r0.notice     = NT_ERROR;
            r0.error_code = ER_BUSY;
          end else if (!in_link_up) begin
            r0.notice     = NT_ERROR;
            r0.error_code = ER_NO_LINK;
          end else begin
            total_nxt      = in_file_size;
            acked_nxt      = 32'd0;
            rem_nxt        = in_file_size;
            retries_nxt    = 4'd0;
            phase_nxt      = PH_WAIT;
            timer_left_nxt = timeout_r;
            timer_run_nxt  = 1'b1;
            r0.frame_kind  = FR_READY_HDR;
            r0.header_size = in_file_size;
          end
        end
        KD_READY: begin
          if (phase_r == PH_WAIT) begin
            phase_nxt      = PH_SEND;
            retries_nxt    = 4'd0;
            r0.frame_kind  = FR_START_HDR;
            r0.header_size = total_r;
            r0.notice      = NT_STARTED;
            two     = 1'b1;
            push    = 1'b1;
            do_send = 1'b1;
          end
        end
        KD_ACK: begin
          if (phase_r == PH_WAIT) begin
            phase_nxt   = PH_SEND;
            retries_nxt = 4'd0;
            r0.notice   = NT_STARTED;
            two     = 1'b1;
            push    = 1'b1;
            do_send = 1'b1;
          end else if (phase_r == PH_SEND) begin
            acked_nxt     = acked_src;
            rem_nxt       = rem_src;
            retries_nxt   = 4'd0;
            r0.notice     = NT_PROGRESS;
            r0.sent_total = acked_src;
            two     = 1'b1;
            push    = 1'b1;
            do_send = 1'b1;
          end
        end
        KD_NAK: begin
          if (phase_r == PH_SEND) begin
            push = 1'b1;
            if (retries_r < retry_limit_r) begin
              retries_nxt = retry_inc;
              do_send     = 1'b1;
            end else begin
              phase_nxt     = PH_IDLE;
              r0.notice     = NT_ERROR;
              r0.error_code = ER_NAKS;
            end
          end
        end
        KD_DEV: begin
          push          = 1'b1;
          phase_nxt     = PH_IDLE;
          r0.notice     = NT_ERROR;
          r0.error_code = ER_DEVICE;
        end
        KD_OTHER: begin
        end
        KD_STOP: begin
          if (phase_r != PH_IDLE) begin
            phase_nxt      = PH_IDLE;
            timer_run_nxt  = 1'b0;
            timer_left_nxt = 20'd0;
          end
        end
        KD_TICK: begin
          if (timer_run_r) begin
            if (timer_left_r > 20'd1) begin
              timer_left_nxt = timer_left_r - 20'd1;
            end else if (phase_r == PH_IDLE) begin
              timer_run_nxt  = 1'b0;
              timer_left_nxt = 20'd0;
            end else begin
              retries_nxt = retry_inc;
              push        = 1'b1;
              if (retry_inc >= retry_limit_r) begin
                phase_nxt      = PH_IDLE;
                timer_run_nxt  = 1'b0;
                timer_left_nxt = 20'd0;
                r0.notice      = NT_ERROR;
                r0.error_code  = ER_TIMEOUTS;
              end else if (phase_r == PH_SEND) begin
                do_send = 1'b1;
              end else begin
                // Still waiting for the receiver: resend the header.
                timer_left_nxt = timeout_r;
                timer_run_nxt  = 1'b1;
                r0.frame_kind  = FR_START_HDR;
                r0.header_size = total_r;
              end
            end
          end
        end
        default: begin
        end
      endcase

      if (do_send) begin
        if (two) begin
          r1 = snd_res;
        end else begin
          r0 = snd_res;
        end
        if (snd_end) begin
          phase_nxt      = PH_IDLE;
          timer_run_nxt  = 1'b0;
          timer_left_nxt = 20'd0;
        end else begin
          block_bytes_nxt = snd_len;
          timer_left_nxt  = timeout_r;
          timer_run_nxt   = 1'b1;
        end
      end
    end

    r0.last = !two;
    r1.last = 1'b1;
  end

  assign push_entry.two  = two;
  assign push_entry.res0 = r0;
  assign push_entry.res1 = r1;

  assign status.phase         = phase_r;
  assign status.timer_running = timer_run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      total_r       <= 32'd0;
      acked_r       <= 32'd0;
      rem_r         <= 32'd0;
      block_bytes_r <= 13'd0;
      retries_r     <= 4'd0;
      timer_left_r  <= 20'd0;
      timer_run_r   <= 1'b0;
      blk_limit_r   <= RST_BLK_LIMIT;
      retry_limit_r <= RST_RETRY_LIMIT;
      timeout_r     <= RST_TIMEOUT;
    end else begin
      phase_r       <= phase_nxt;
      total_r       <= total_nxt;
      acked_r       <= acked_nxt;
      rem_r         <= rem_nxt;
      block_bytes_r <= block_bytes_nxt;
      retries_r     <= retries_nxt;
      timer_left_r  <= timer_left_nxt;
      timer_run_r   <= timer_run_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_BLK_LIMIT) begin
          blk_limit_r <= cfg_wdata[12:0];
        end
        if (cfg_index == CFG_RETRY_LIMIT) begin
          retry_limit_r <= cfg_wdata[3:0];
        end
        if (cfg_index == CFG_TIMEOUT) begin
          timeout_r <= cfg_wdata[19:0];
        end
      end
    end
  end

endmodule

// ===== src/btas_fifo.sv =====
module btas_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [Width-1:0]               wr_data,
  input  logic                           pop,
  output logic [Width-1:0]               rd_data,
  output logic                           full,
  output logic                           empty,
  output logic [$clog2(Depth+1)-1:0]     count
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CntW'(Depth));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/btas_back.sv =====
module btas_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  btas_pkg::entry_t        q_data,
  output logic                    q_pop,
  input  logic                    out_tready,
  output logic                    out_valid,
  output btas_pkg::res_t          out_res,
  output btas_pkg::back_status_t  status
);
  import btas_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic pend_valid_r, pend_valid_nxt;
  res_t out_res_r, out_res_nxt;
  res_t pend_r, pend_nxt;
  logic load;

  // The output register reloads whenever it is empty or its word is taken.
  assign load  = !out_valid_r || out_tready;
  assign q_pop = load && !pend_valid_r && !q_empty;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    pend_valid_nxt = pend_valid_r;
    out_res_nxt    = out_res_r;
    pend_nxt       = pend_r;
    if (load) begin
      if (pend_valid_r) begin
        out_res_nxt    = pend_r;
        out_valid_nxt  = 1'b1;
        pend_valid_nxt = 1'b0;
      end else if (!q_empty) begin
        out_res_nxt    = q_data.res0;
        pend_nxt       = q_data.res1;
        pend_valid_nxt = q_data.two;
        out_valid_nxt  = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    pend_r    <= pend_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_res           = out_res_r;
  assign status.pend_valid = pend_valid_r;
  assign status.out_valid  = out_valid_r;

endmodule

// ===== src/block_transfer_arq_sender.sv =====
// Channel   Direction  tdata (low bit up)                       tuser / tlast
// in_       slave      file_size[31:0], link_up[32], pad to 40  tuser: kind
// out_      master     block_offset, block_length, header_size,  tuser: frame_kind,
//                      error_code, sent_total (112 bits)        notice; tlast: last
// cfg_      write      index 0 block limit, 1 retry limit, 2 timeout ticks
//
// One input word is accepted per cycle while the result queue has room.
// Results leave at one per cycle while out_tready is high; an input that yields
// two results needs two transfers, so the output port sets the sustained rate
// under such traffic. An accepted input is written into the queue, and its
// result then loads from the queue into the output register.
// rst_n is synchronous; it empties the queue and returns to idle with the
// default configuration. A stalled output fills the queue, then drops in_tready.
`include "block_transfer_arq_sender_defines.svh"

module block_transfer_arq_sender #(
  parameter int unsigned FifoDepth = btas_pkg::FIFO_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [btas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [btas_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [39:0]                         in_tdata,  // file_size, link_up
  input  logic [2:0]                          in_tuser,  // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // block_offset, block_length, header_size, error_code, sent_total
  output logic [111:0]                        out_tdata,
  output logic [5:0]                          out_tuser, // frame_kind, notice
  output logic                                out_tlast
);
  import btas_pkg::*;

  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  logic            in_fire;
  kind_t           in_kind;
  logic            push;
  entry_t          push_entry;
  entry_t          q_data;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  logic [CntW-1:0] q_count;
  res_t            out_res;
  front_status_t   front_st;
  back_status_t    back_st;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;
  assign in_kind   = kind_t'(in_tuser);

  btas_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_fire      (in_fire),
    .in_kind      (in_kind),
    .in_file_size (in_tdata[31:0]),
    .in_link_up   (in_tdata[32]),
    .push         (push),
    .push_entry   (push_entry),
    .status       (front_st)
  );

  btas_fifo #(
    .Width ($bits(entry_t)),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_entry),
    .pop     (q_pop),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty),
    .count   (q_count)
  );

  btas_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_res    (out_res),
    .status     (back_st)
  );

  assign out_tdata = {out_res.sent_total, out_res.error_code, out_res.header_size,
                      out_res.block_length, out_res.block_offset};
  assign out_tuser = {out_res.notice, out_res.frame_kind};
  assign out_tlast = out_res.last;

  `BTAS_ASSERT_IMP(a_queue_bound, 1'b1, q_count <= CntW'(FifoDepth))
  `BTAS_ASSERT_IMP(a_idle_timer_off, front_st.phase == PH_IDLE, !front_st.timer_running)
  `BTAS_ASSERT_IMP(a_pend_behind_out, back_st.pend_valid, out_tvalid)
  `BTAS_ASSERT_NXT(a_stop_to_idle, in_fire && in_kind == KD_STOP, front_st.phase == PH_IDLE)

endmodule
